[hdl/button_click_hold_detector_macros.svh]
`ifndef BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BCHD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bchd same-cycle check failed");

// next-cycle implication, checked outside reset
`define BCHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bchd next-cycle check failed");

`endif

[hdl/bchd_pkg.sv]
`timescale 1ns / 1ps

package bchd_pkg;

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int EV_W    = 3;
  localparam int PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRESSED = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT2   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT3   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_HELD    = 3'd4;

  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_CLICK   = 3'd1;
  localparam logic [EV_W-1:0] EV_DOUBLE  = 3'd2;
  localparam logic [EV_W-1:0] EV_TRIPLE  = 3'd3;
  localparam logic [EV_W-1:0] EV_HOLD    = 3'd4;
  localparam logic [EV_W-1:0] EV_RELEASE = 3'd5;

  localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] REG_CLICK_MAX = 2'd1;
  localparam logic [1:0] REG_HOLD      = 2'd2;
  localparam logic [1:0] REG_CLICK_GAP = 2'd3;

  localparam logic [CFG_W-1:0] RST_DEBOUNCE  = 16'd20;
  localparam logic [CFG_W-1:0] RST_CLICK_MAX = 16'd300;
  localparam logic [CFG_W-1:0] RST_HOLD      = 16'd1500;
  localparam logic [CFG_W-1:0] RST_CLICK_GAP = 16'd300;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] click_max_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] click_gap_ms;
  } cfg_t;

  // debounced sample handed from front to back
  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] now;
  } sample_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_code;
    logic              is_pressed;
    logic [TIME_W-1:0] held_time_ms;
  } result_t;

  typedef struct packed {
    logic valid;
    logic full;
  } link_stat_t;

endpackage

[hdl/button_click_hold_detector.sv]
// Button click / hold detector. Each pushed item is one poll of the active-low
// pin with a millisecond timestamp; each poll yields exactly one result, in
// order, holding the event (none, click, double, triple, hold, release), the
// debounced level and the current press duration. The front end debounces and
// accepts one poll per clock unless its two-entry queue is full, which stalls
// input; that queue feeds the press classifier, which retires one poll per
// clock into a two-entry result queue while it has room, so the rate is one
// item per cycle unless the receiver stalls. Each poll passes the front queue,
// then the result queue. The user writes thresholds over APB (byte addresses
// 0, 4, 8, 12) only while no item is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "button_click_hold_detector_macros.svh"

module button_click_hold_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          pin_level,
  input  logic [bchd_pkg::TIME_W-1:0]   now_ms,
  output logic                          empty,
  input  logic                          pop,
  output logic [bchd_pkg::EV_W-1:0]     event_code,
  output logic                          is_pressed,
  output logic [bchd_pkg::TIME_W-1:0]   held_time_ms,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bchd_pkg::ADDR_W-1:0]   paddr,
  input  logic [bchd_pkg::DATA_W-1:0]   pwdata,
  output logic [bchd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import bchd_pkg::*;

  cfg_t       cfg;
  sample_t    smp_in;
  sample_t    smp_out;
  logic       smp_push;
  logic       link_pop;
  link_stat_t link;

  bchd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bchd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pin_level   (pin_level),
    .now_ms      (now_ms),
    .debounce_ms (cfg.debounce_ms),
    .link_full   (link.full),
    .smp_push    (smp_push),
    .smp         (smp_in)
  );

  bchd_link_q u_link (
    .clk     (clk),
    .rst     (rst),
    .wr      (smp_push),
    .wr_data (smp_in),
    .rd      (link_pop),
    .rd_data (smp_out),
    .stat    (link)
  );

  bchd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .link         (link),
    .smp          (smp_out),
    .link_pop     (link_pop),
    .empty        (empty),
    .pop          (pop),
    .event_code   (event_code),
    .is_pressed   (is_pressed),
    .held_time_ms (held_time_ms)
  );

  `BCHD_ASSERT_NOW(a_hold_pressed, !empty && event_code == EV_HOLD, is_pressed)
  `BCHD_ASSERT_NOW(a_release_up, !empty && event_code == EV_RELEASE, !is_pressed)
  `BCHD_ASSERT_NOW(a_up_no_time, !empty && !is_pressed, held_time_ms == '0)
  `BCHD_ASSERT_NEXT(a_link_fill, smp_push && !link_pop, link.valid)

endmodule

[hdl/bchd_cfg.sv]
`timescale 1ns / 1ps

module bchd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bchd_pkg::ADDR_W-1:0]   paddr,
  input  logic [bchd_pkg::DATA_W-1:0]   pwdata,
  output logic [bchd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output bchd_pkg::cfg_t                cfg
);
  import bchd_pkg::*;

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms  <= RST_DEBOUNCE;
      cfg.click_max_ms <= RST_CLICK_MAX;
      cfg.hold_ms      <= RST_HOLD;
      cfg.click_gap_ms <= RST_CLICK_GAP;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:  cfg.debounce_ms  <= pwdata[CFG_W-1:0];
        REG_CLICK_MAX: cfg.click_max_ms <= pwdata[CFG_W-1:0];
        REG_HOLD:      cfg.hold_ms      <= pwdata[CFG_W-1:0];
        REG_CLICK_GAP: cfg.click_gap_ms <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DEBOUNCE:  prdata[CFG_W-1:0] = cfg.debounce_ms;
      REG_CLICK_MAX: prdata[CFG_W-1:0] = cfg.click_max_ms;
      REG_HOLD:      prdata[CFG_W-1:0] = cfg.hold_ms;
      REG_CLICK_GAP: prdata[CFG_W-1:0] = cfg.click_gap_ms;
      default: ;
    endcase
  end

endmodule

[hdl/bchd_front.sv]
`timescale 1ns / 1ps

module bchd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          pin_level,
  input  logic [bchd_pkg::TIME_W-1:0]   now_ms,
  input  logic [bchd_pkg::CFG_W-1:0]    debounce_ms,
  input  logic                          link_full,
  output logic                          smp_push,
  output bchd_pkg::sample_t             smp
);
  import bchd_pkg::*;

  logic              stable_level;
  logic [TIME_W-1:0] last_accept_time;
  logic              raw;
  logic [TIME_W-1:0] elapsed;
  logic              change;

  assign full     = link_full;
  assign smp_push = push && !link_full;
  assign raw      = !pin_level;
  assign elapsed  = now_ms - last_accept_time;
  // lockout: a level change is taken only after the debounce window
  assign change   = (raw != stable_level) &&
                    (elapsed >= {{(TIME_W-CFG_W){1'b0}}, debounce_ms});

  assign smp.level = change ? raw : stable_level;
  assign smp.now   = now_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level     <= 1'b0;
      last_accept_time <= '0;
    end else if (smp_push && change) begin
      stable_level     <= raw;
      last_accept_time <= now_ms;
    end
  end

endmodule

[hdl/bchd_link_q.sv]
`timescale 1ns / 1ps

module bchd_link_q (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  bchd_pkg::sample_t    wr_data,
  input  logic                 rd,
  output bchd_pkg::sample_t    rd_data,
  output bchd_pkg::link_stat_t stat
);
  import bchd_pkg::*;

  sample_t    mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign stat.valid = (count != 2'd0);
  assign stat.full  = (count == 2'd2);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && stat.valid;
  assign rd_data    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= !wptr;
      if (do_rd) rptr <= !rptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

[hdl/bchd_back.sv]
`timescale 1ns / 1ps

module bchd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bchd_pkg::cfg_t                cfg,
  input  bchd_pkg::link_stat_t          link,
  input  bchd_pkg::sample_t             smp,
  output logic                          link_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [bchd_pkg::EV_W-1:0]     event_code,
  output logic                          is_pressed,
  output logic [bchd_pkg::TIME_W-1:0]   held_time_ms
);
  import bchd_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [TIME_W-1:0]  press_start, press_start_next;
  logic [TIME_W-1:0]  release_start, release_start_next;
  logic               hold_reported, hold_reported_next;
  logic [1:0]         clicks_so_far, clicks_so_far_next;

  logic [TIME_W-1:0]  dur;
  logic [TIME_W-1:0]  gap;
  logic [1:0]         clicks_inc;
  result_t            res;

  // result queue
  result_t            oq [2];
  logic               owptr;
  logic               orptr;
  logic [1:0]         ocount;
  logic               fire;
  logic               do_pop;

  assign empty    = (ocount == 2'd0);
  assign do_pop   = pop && !empty;
  assign fire     = link.valid && (ocount != 2'd2);
  assign link_pop = fire;

  assign dur        = smp.now - press_start;
  assign gap        = smp.now - release_start;
  assign clicks_inc = clicks_so_far + 2'd1;

  always_comb begin
    phase_next         = phase;
    press_start_next   = press_start;
    release_start_next = release_start;
    hold_reported_next = hold_reported;
    clicks_so_far_next = clicks_so_far;
    res.event_code     = EV_NONE;
    unique case (phase)
      PH_PRESSED: begin
        if (!smp.level) begin
          release_start_next = smp.now;
          if (dur < {{(TIME_W-CFG_W){1'b0}}, cfg.click_max_ms}) begin
            if (clicks_inc == 2'd0 || clicks_inc == 2'd3) begin
              res.event_code     = EV_TRIPLE;
              clicks_so_far_next = 2'd0;
              phase_next         = PH_IDLE;
            end else begin
              clicks_so_far_next = clicks_inc;
              phase_next         = (clicks_inc == 2'd2) ? PH_WAIT3 : PH_WAIT2;
            end
          end else begin
            clicks_so_far_next = 2'd0;
            phase_next         = PH_IDLE;
            if (hold_reported) res.event_code = EV_RELEASE;
          end
        end else if (dur >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_ms} && !hold_reported) begin
          hold_reported_next = 1'b1;
          clicks_so_far_next = 2'd0;
          phase_next         = PH_HELD;
          res.event_code     = EV_HOLD;
        end
      end
      PH_WAIT2, PH_WAIT3: begin
        if (smp.level) begin
          press_start_next   = smp.now;
          hold_reported_next = 1'b0;
          phase_next         = PH_PRESSED;
        end else if (gap >= {{(TIME_W-CFG_W){1'b0}}, cfg.click_gap_ms}) begin
          res.event_code     = (phase == PH_WAIT2) ? EV_CLICK : EV_DOUBLE;
          clicks_so_far_next = 2'd0;
          phase_next         = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!smp.level) begin
          res.event_code     = EV_RELEASE;
          clicks_so_far_next = 2'd0;
          phase_next         = PH_IDLE;
        end
      end
      default: begin
        // idle, and unused codes behave as idle
        if (smp.level) begin
          press_start_next   = smp.now;
          hold_reported_next = 1'b0;
          clicks_so_far_next = 2'd0;
          phase_next         = PH_PRESSED;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
    res.is_pressed   = smp.level;
    res.held_time_ms = (phase_next == PH_PRESSED || phase_next == PH_HELD) ?
                       (smp.now - press_start_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      press_start   <= '0;
      release_start <= '0;
      hold_reported <= 1'b0;
      clicks_so_far <= 2'd0;
    end else if (fire) begin
      phase         <= phase_next;
      press_start   <= press_start_next;
      release_start <= release_start_next;
      hold_reported <= hold_reported_next;
      clicks_so_far <= clicks_so_far_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      oq[owptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= 1'b0;
      orptr  <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (fire)   owptr <= !owptr;
      if (do_pop) orptr <= !orptr;
      ocount <= ocount + {1'b0, fire} - {1'b0, do_pop};
    end
  end

  assign event_code   = oq[orptr].event_code;
  assign is_pressed   = oq[orptr].is_pressed;
  assign held_time_ms = oq[orptr].held_time_ms;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bchd_pkg::*;

  localparam logic PIN_DOWN = 1'b0;
  localparam logic PIN_UP   = 1'b1;
  localparam logic [1:0] TRIPLE_COUNT = 2'd3;
  // longest legal quiet stretch is the receiver hold-off (HOLDOFF_CYCLES) plus a few
  // register accesses and drain cycles; this leaves ample margin
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 300;

  // Tracks the debouncer and press classifier and queues one expected result
  // per accepted poll.
  class poll_scoreboard;
    logic [CFG_W-1:0]   debounce_ms, click_max_ms, hold_ms, click_gap_ms;
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  press_start, release_start, last_change;
    logic               stable_down, hold_seen;
    logic [1:0]         clicks;
    result_t            expected_q[$];
    int                 errors, results_checked;
    int                 event_hits[6];

    function new();
      debounce_ms   = RST_DEBOUNCE;
      click_max_ms  = RST_CLICK_MAX;
      hold_ms       = RST_HOLD;
      click_gap_ms  = RST_CLICK_GAP;
      phase         = PH_IDLE;
      press_start   = '0;
      release_start = '0;
      last_change   = '0;
      stable_down   = 1'b0;
      hold_seen     = 1'b0;
      clicks        = 2'd0;
      errors        = 0;
      results_checked = 0;
      foreach (event_hits[i]) event_hits[i] = 0;
    endfunction

    function logic [TIME_W-1:0] ms_since(logic [TIME_W-1:0] now, logic [TIME_W-1:0] t);
      return now - t;
    endfunction

    function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_DEBOUNCE:  debounce_ms  = value[CFG_W-1:0];
        REG_CLICK_MAX: click_max_ms = value[CFG_W-1:0];
        REG_HOLD:      hold_ms      = value[CFG_W-1:0];
        REG_CLICK_GAP: click_gap_ms = value[CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_DEBOUNCE:  return DATA_W'(debounce_ms);
        REG_CLICK_MAX: return DATA_W'(click_max_ms);
        REG_HOLD:      return DATA_W'(hold_ms);
        default:       return DATA_W'(click_gap_ms);
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_poll(logic pin, logic [TIME_W-1:0] now);
      result_t          r;
      logic             raw_down;
      logic [TIME_W-1:0] dur;
      raw_down = (pin == PIN_DOWN);
      r.event_code = EV_NONE;

      // lockout debounce: a change counts only after debounce_ms since the last one
      if (raw_down != stable_down && ms_since(now, last_change) >= debounce_ms) begin
        stable_down = raw_down;
        last_change = now;
      end

      case (phase)
        PH_PRESSED: begin
          if (!stable_down) begin
            dur = ms_since(now, press_start);
            release_start = now;
            if (dur < click_max_ms) begin
              clicks = clicks + 2'd1;
              if (clicks == 2'd0 || clicks >= TRIPLE_COUNT) begin
                r.event_code = EV_TRIPLE;
                clicks = 2'd0;
                phase = PH_IDLE;
              end else if (clicks == 2'd2) begin
                phase = PH_WAIT3;
              end else begin
                phase = PH_WAIT2;
              end
            end else begin
              // too long for a click, no hold reported yet: drop everything
              clicks = 2'd0;
              phase = PH_IDLE;
              if (hold_seen) r.event_code = EV_RELEASE;
            end
          end else if (ms_since(now, press_start) >= hold_ms && !hold_seen) begin
            hold_seen = 1'b1;
            clicks = 2'd0;
            phase = PH_HELD;
            r.event_code = EV_HOLD;
          end
        end
        PH_WAIT2, PH_WAIT3: begin
          if (stable_down) begin
            press_start = now;
            hold_seen = 1'b0;
            phase = PH_PRESSED;
          end else if (ms_since(now, release_start) >= click_gap_ms) begin
            r.event_code = (phase == PH_WAIT2) ? EV_CLICK : EV_DOUBLE;
            clicks = 2'd0;
            phase = PH_IDLE;
          end
        end
        PH_HELD: begin
          if (!stable_down) begin
            r.event_code = EV_RELEASE;
            clicks = 2'd0;
            phase = PH_IDLE;
          end
        end
        default: begin
          if (stable_down) begin
            press_start = now;
            hold_seen = 1'b0;
            clicks = 2'd0;
            phase = PH_PRESSED;
          end else begin
            phase = PH_IDLE;
          end
        end
      endcase

      r.is_pressed = stable_down;
      r.held_time_ms = (phase == PH_PRESSED || phase == PH_HELD) ?
                       ms_since(now, press_start) : '0;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [EV_W-1:0] ev, logic pressed, logic [TIME_W-1:0] held);
      result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no poll pending: event %0d pressed %0d held %0d",
                 $time, ev, pressed, held);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      results_checked++;
      if (r.event_code <= EV_RELEASE) event_hits[r.event_code]++;
      if (ev !== r.event_code) begin
        $display("%0t: event_code mismatch: expected %0d, actual %0d",
                 $time, r.event_code, ev);
        errors++;
      end
      if (pressed !== r.is_pressed) begin
        $display("%0t: is_pressed mismatch: expected %0d, actual %0d",
                 $time, r.is_pressed, pressed);
        errors++;
      end
      if (held !== r.held_time_ms) begin
        $display("%0t: held_time_ms mismatch: expected %0d, actual %0d",
                 $time, r.held_time_ms, held);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic                pin_level = PIN_UP;
  logic [TIME_W-1:0]   now_ms = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [EV_W-1:0]     event_code;
  logic                is_pressed;
  logic [TIME_W-1:0]   held_time_ms;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  poll_scoreboard      sb;
  logic [TIME_W-1:0]   clock_ms = '0;
  int                  polls_sent = 0;
  int                  burst_left = 0;
  int                  idle_cycles = 0;
  bit                  holdoff_req = 1'b0;
  int                  holdoff_left = 0;
  int                  rx_mode = 0;
  int                  rx_mode_left = 0;
  int                  settings_run = 1;

  button_click_hold_detector uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pin_level    (pin_level),
    .now_ms       (now_ms),
    .empty        (empty),
    .pop          (pop),
    .event_code   (event_code),
    .is_pressed   (is_pressed),
    .held_time_ms (held_time_ms),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // receiver: checks each popped item, stalls on a mode that changes every so often
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(event_code, is_pressed, held_time_ms);
      if (holdoff_req) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        pop <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(20, 80);
        end
        rx_mode_left--;
        case (rx_mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no item moved for %0d cycles", $time, idle_cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_poll(logic pin, logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    pin_level <= pin;
    now_ms <= t;
    do @(posedge clk); while (full);
    sb.note_poll(pin, t);
    polls_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic apb_write(logic [1:0] idx, logic [CFG_W-1:0] value);
    logic [DATA_W-1:0] word;
    word = $urandom();
    word[CFG_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, word);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(logic [1:0] idx, output logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_regs();
    logic [DATA_W-1:0] got;
    for (int i = 0; i < 4; i++) begin
      apb_read(2'(i), got);
      if (got !== sb.reg_value(2'(i))) begin
        $display("%0t: register %0d readback: expected %0d, actual %0d",
                 $time, i, sb.reg_value(2'(i)), got);
        sb.errors++;
      end
    end
  endtask

  task automatic configure(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] clk_max,
                           logic [CFG_W-1:0] hld, logic [CFG_W-1:0] gap);
    apb_write(REG_DEBOUNCE, deb);
    apb_write(REG_CLICK_MAX, clk_max);
    apb_write(REG_HOLD, hld);
    apb_write(REG_CLICK_GAP, gap);
    check_regs();
  endtask

  // threshold value that is zero one time in four
  function automatic logic [CFG_W-1:0] maybe_zero();
    return ($urandom_range(0, 3) == 0) ? '0 : CFG_W'($urandom_range(0, 65535));
  endfunction

  // reset thresholds: debounce 20, click 300, hold 1500, gap 300
  task automatic run_directed();
    send_poll(PIN_DOWN, 32'd10);     // too soon after reset, locked out
    send_poll(PIN_DOWN, 32'd30);
    send_poll(PIN_UP,   32'd40);     // bounce inside lockout
    send_poll(PIN_UP,   32'd130);
    send_poll(PIN_DOWN, 32'd200);
    send_poll(PIN_UP,   32'd300);
    send_poll(PIN_DOWN, 32'd400);
    send_poll(PIN_UP,   32'd500);    // third release: triple at once
    send_poll(PIN_DOWN, 32'd1000);
    send_poll(PIN_UP,   32'd1100);
    send_poll(PIN_UP,   32'd1500);   // gap expired: single click
    send_poll(PIN_DOWN, 32'd2000);
    send_poll(PIN_UP,   32'd2100);
    send_poll(PIN_DOWN, 32'd2200);
    send_poll(PIN_UP,   32'd2300);
    send_poll(PIN_UP,   32'd2700);   // double
    send_poll(PIN_DOWN, 32'd3000);
    send_poll(PIN_UP,   32'd3500);   // long press, under hold: no event
    send_poll(PIN_DOWN, 32'd4000);
    send_poll(PIN_UP,   32'd4100);
    send_poll(PIN_DOWN, 32'd4200);
    send_poll(PIN_DOWN, 32'd5800);   // hold wipes the pending click
    send_poll(PIN_UP,   32'd6000);
    send_poll(PIN_DOWN, 32'hFFFF_FFF0);
    send_poll(PIN_UP,   32'h0000_0030);  // press spans the timestamp wrap
    send_poll(PIN_UP,   32'h0000_0010);  // time steps back: reads as a long gap
  endtask

  // keep the pin at one level for about dur ms, bouncing inside the lockout window
  task automatic hold_level(logic level, int unsigned dur);
    int unsigned elapsed, step_max, step;
    logic pin;
    elapsed = 0;
    step_max = dur / 6 + 1;
    do begin
      step = $urandom_range(0, step_max);
      clock_ms += step;
      elapsed += step;
      pin = level;
      if (elapsed < sb.debounce_ms && $urandom_range(0, 3) == 0) pin = ~level;
      send_poll(pin, clock_ms);
    end while (elapsed < dur);
  endtask

  task automatic run_gestures(int n);
    int stop_at, kind;
    int unsigned c, h, g, press_len, gap_len;
    stop_at = polls_sent + n;
    while (polls_sent < stop_at) begin
      c = sb.click_max_ms;
      h = sb.hold_ms;
      g = sb.click_gap_ms;
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        // noise: random levels with timestamps jumping anywhere
        repeat ($urandom_range(2, 6)) begin
          if ($urandom_range(0, 1)) clock_ms = $urandom();
          else clock_ms = clock_ms - $urandom_range(0, 100);
          send_poll(1'($urandom_range(0, 1)), clock_ms);
        end
      end else begin
        if (kind < 5)
          press_len = (c == 0) ? 0 : $urandom_range(0, c - 1);
        else if (kind < 7)
          press_len = (h > c) ? $urandom_range(c, h - 1) : c;
        else
          press_len = h + $urandom_range(0, h / 2 + 10);
        if ($urandom_range(0, 9) < 6) gap_len = $urandom_range(0, g);
        else gap_len = g + $urandom_range(0, g + 10);
        hold_level(PIN_DOWN, press_len);
        hold_level(PIN_UP, gap_len);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_regs();
    run_directed();
    drain_results();

    for (int s = 0; s < 5; s++) begin
      case (s)
        0: configure(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(50, 400)),
                     CFG_W'($urandom_range(500, 3000)), CFG_W'($urandom_range(50, 400)));
        1: configure(16'd0, 16'd0, 16'd0, 16'd0);
        2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: configure(maybe_zero(), maybe_zero(), maybe_zero(), maybe_zero());
        default: configure(CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(10, 100)),
                           CFG_W'($urandom_range(100, 400)),
                           CFG_W'($urandom_range(10, 100)));
      endcase
      settings_run++;
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : $urandom();
      if (s == 0) holdoff_req = 1'b1;   // long receiver stall while polls keep coming
      if (s == 3) begin
        run_gestures(150);
        drain_results();
        run_gestures(150);
      end else begin
        run_gestures(300);
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("run covered %0d polls under %0d threshold settings, incl. zero and max",
             polls_sent, settings_run);
    $display("events seen: click %0d double %0d triple %0d hold %0d release %0d",
             sb.event_hits[EV_CLICK], sb.event_hits[EV_DOUBLE], sb.event_hits[EV_TRIPLE],
             sb.event_hits[EV_HOLD], sb.event_hits[EV_RELEASE]);
    if (sb.errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/bchd_pkg.sv
hdl/bchd_cfg.sv
hdl/bchd_front.sv
hdl/bchd_link_q.sv
hdl/bchd_back.sv
hdl/button_click_hold_detector.sv
dv/tb.sv
